// ===== src/sdc_pkg.sv =====
// sdc_pkg: constants, types and the CRC-32 byte update for the SLIP deframer.
// Used by sdc_frame_upd, slip_deframer_crc_packet_check and sdc_checker; depends on nothing.
package sdc_pkg;

	localparam int unsigned MAX_FRAME       = 512;
	localparam int unsigned NUM_DESCRIPTORS = 4;
	localparam int unsigned NUM_CHANNELS    = 2;
	localparam int unsigned MAX_REPORT      = 64;

	localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);
	localparam int unsigned CH_W  = 1;

	localparam logic [7:0] SLIP_END      = 8'o300;
	localparam logic [7:0] SLIP_ESC      = 8'o333;
	localparam logic [7:0] SLIP_ESC_END  = 8'o334;
	localparam logic [7:0] SLIP_ESC_ESC  = 8'o335;
	localparam logic [7:0] PROTO_VERSION = 8'd1;
	localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

	typedef enum logic {
		KIND_DATA    = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		VERD_OK       = 3'd0,
		VERD_NEW_DESC = 3'd1,
		VERD_CRC      = 3'd2,
		VERD_RUNT     = 3'd3,
		VERD_NO_HDR   = 3'd4,
		VERD_REJECT   = 3'd5,
		VERD_OVERLONG = 3'd6
	} verdict_t;

	// per-channel state word held in the state RAM
	typedef struct packed {
		logic             esc;
		logic [CNT_W-1:0] cnt;
		logic [31:0]      crc;
		logic [31:0]      hold;
		logic [31:0]      hdr;
		logic             ovl;
	} chan_state_t;

	localparam chan_state_t CHAN_RESET = '{
		esc:  1'b0,
		cnt:  '0,
		crc:  32'hFFFF_FFFF,
		hold: 32'h0,
		hdr:  32'h0,
		ovl:  1'b0
	};

	// result of one state update
	typedef struct packed {
		logic        emit;
		kind_t       kind;
		logic [7:0]  data;
		verdict_t    verdict;
		logic [7:0]  rid;
		logic [7:0]  desc;
		logic [6:0]  plen;
	} upd_res_t;

	// reflected CRC-32, one byte, bit at a time
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== src/sdc_in_if.sv =====
// sdc_in_if: valid/ready channel carrying one received serial byte.
// Depends on nothing.
interface sdc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;
	logic       channel;

	modport source (output valid, output byte_in, output channel, input ready);
	modport sink   (input valid, input byte_in, input channel, output ready);
endinterface

// ===== src/sdc_out_if.sv =====
// sdc_out_if: valid/ready channel carrying one deframer result.
// Depends on nothing.
interface sdc_out_if;
	logic       valid;
	logic       ready;
	logic       result_kind;
	logic       out_channel;
	logic [7:0] data_byte;
	logic [2:0] verdict;
	logic [7:0] rep_id;
	logic [7:0] frame_descriptor;
	logic [6:0] payload_length;

	modport source (output valid, output result_kind, output out_channel, output data_byte,
		output verdict, output rep_id, output frame_descriptor, output payload_length,
		input ready);
	modport sink   (input valid, input result_kind, input out_channel, input data_byte,
		input verdict, input rep_id, input frame_descriptor, input payload_length,
		output ready);
endinterface

// ===== src/sdc_ram.sv =====
// sdc_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module sdc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule

// ===== src/sdc_frame_upd.sv =====
// sdc_frame_upd: read-modify-write step on one channel's state for one byte.
// Depends on sdc_pkg.
module sdc_frame_upd
	import sdc_pkg::*;
(
	input  chan_state_t cur,
	input  logic [7:0]  byte_in,
	input  logic [1:0]  cur_desc,
	output chan_state_t nxt,
	output upd_res_t    res
);
	logic             push;
	logic [7:0]       d;
	logic [7:0]       old;
	logic [CNT_W-1:0] idx;
	logic [CNT_W-1:0] len;
	logic             have_hdr;
	logic [7:0]       h_ver, h_desc, h_len, h_rid;

	assign old    = cur.hold[7:0];
	assign idx    = cur.cnt - CNT_W'(4);
	assign len    = cur.cnt - CNT_W'(8);
	assign h_ver  = cur.hdr[7:0];
	assign h_desc = cur.hdr[15:8];
	assign h_len  = cur.hdr[23:16];
	assign h_rid  = cur.hdr[31:24];
	assign have_hdr = 32'(cur.cnt) >= 32'd8;

	always_comb begin
		nxt  = cur;
		res  = '0;
		push = 1'b0;
		d    = byte_in;

		if (cur.esc) begin
			nxt.esc = 1'b0;
			push    = 1'b1;
			if (byte_in == SLIP_ESC_END) begin
				d = SLIP_END;
			end else if (byte_in == SLIP_ESC_ESC) begin
				d = SLIP_ESC;
			end
		end else if (byte_in == SLIP_END) begin
			res.emit = 1'b1;
			res.kind = KIND_VERDICT;
			if (cur.ovl) begin
				res.verdict = VERD_OVERLONG;
			end else if (32'(cur.cnt) <= 32'd4) begin
				res.verdict = VERD_RUNT;
			end else if (~cur.crc != cur.hold) begin
				res.verdict = VERD_CRC;
			end else if (!have_hdr) begin
				res.verdict = VERD_NO_HDR;
			end else if (h_ver != PROTO_VERSION || 32'(h_len) != 32'(len)
				|| 32'(len) > MAX_REPORT || 32'(h_desc) >= NUM_DESCRIPTORS
				|| (h_rid == 8'd0 && 32'(len) >= MAX_REPORT)) begin
				res.verdict = VERD_REJECT;
			end else begin
				res.verdict = (h_desc != {6'd0, cur_desc}) ? VERD_NEW_DESC : VERD_OK;
				res.plen    = len[6:0];
			end
			if (have_hdr) begin
				res.rid  = h_rid;
				res.desc = h_desc;
			end
			nxt = CHAN_RESET;
		end else if (byte_in == SLIP_ESC) begin
			nxt.esc = 1'b1;
		end else begin
			push = 1'b1;
		end

		if (push) begin
			if (32'(cur.cnt) >= MAX_FRAME) begin
				// frame full: drop the byte, remember it
				nxt.ovl = 1'b1;
			end else begin
				if (32'(cur.cnt) >= 32'd4) begin
					nxt.crc = crc_byte(cur.crc, old);
					if (32'(idx) < 32'd4) begin
						nxt.hdr = cur.hdr | (32'(old) << {idx[1:0], 3'b000});
					end
					res.emit = 1'b1;
					res.kind = KIND_DATA;
					res.data = old;
				end
				nxt.hold = {d, cur.hold[31:8]};
				nxt.cnt  = cur.cnt + CNT_W'(1);
			end
		end
	end
endmodule

// ===== src/slip_deframer_crc_packet_check.sv =====
// slip_deframer_crc_packet_check: top level of the SLIP deframer with CRC-32 and header check.
// Depends on sdc_pkg, sdc_in_if, sdc_out_if, sdc_ram and sdc_frame_upd.
//
//  port      | dir  | transaction
//  ----------+------+------------------------------------------------------
//  rx        | in   | one raw serial byte plus its channel number
//  res       | out  | one decoded data byte or one end-of-frame verdict
//  cfg_wr_*  | in   | write of current_descriptor, taken on any cycle with cfg_wr_en
//
//  One byte per cycle sustained while res is not stalled, one result at most per byte. The
//  result is registered: state RAM read at the accepting edge, then update, write-back
//  and output register load when the update stage advances.
//  Same-channel bytes in consecutive cycles use the forwarded write-back word.
//  After reset each channel's RAM entry reads as the cleared state until first
//  written (one valid flop per channel); no clearing pass, ready straight away.
//  rx stalls only while a result sits in the update stage and the output
//  register holds an untaken result.
module slip_deframer_crc_packet_check
	import sdc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [1:0]       cfg_wr_data,
	sdc_in_if.sink           rx,
	sdc_out_if.source        res
);
	localparam int unsigned SW = $bits(chan_state_t);

	logic [1:0] cur_desc_q;

	// update stage
	logic             s1_valid_q;
	logic [7:0]       byte_s1;
	logic [CH_W-1:0]  ch_s1;
	logic             fwd_hit_s1;
	chan_state_t      fwd_st_s1;
	logic             vld_s1;

	logic [NUM_CHANNELS-1:0] vld_q;     // entry has been written since reset

	logic [SW-1:0] ram_rd;
	chan_state_t   cur_st;
	chan_state_t   nxt_st;
	upd_res_t      upd;

	logic out_valid_q;
	logic out_free;
	logic s1_go;
	logic accept;
	logic in_range_s1;
	logic wr_en;

	// output register payload
	logic       kind_q;
	logic       och_q;
	logic [7:0] data_q;
	logic [2:0] verdict_q;
	logic [7:0] rid_q;
	logic [7:0] desc_q;
	logic [6:0] plen_q;

	assign in_range_s1 = 32'(ch_s1) < NUM_CHANNELS;
	assign out_free = !out_valid_q || res.ready;
	// stage frees if empty, has nothing to show, or output register has room
	assign s1_go    = !s1_valid_q || !(upd.emit && in_range_s1) || out_free;
	assign rx.ready = s1_go;
	assign accept   = rx.valid && rx.ready;
	assign wr_en    = s1_valid_q && s1_go && in_range_s1;

	sdc_ram #(
		.WIDTH (SW),
		.DEPTH (NUM_CHANNELS)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (ch_s1),
		.wr_data (nxt_st),
		.rd_en   (accept),
		.rd_addr (rx.channel),
		.rd_data (ram_rd)
	);

	// pick forwarded word, RAM word, or cleared state for unwritten entries
	always_comb begin
		if (fwd_hit_s1) begin
			cur_st = fwd_st_s1;
		end else if (vld_s1) begin
			cur_st = chan_state_t'(ram_rd);
		end else begin
			cur_st = CHAN_RESET;
		end
	end

	sdc_frame_upd u_upd (
		.cur      (cur_st),
		.byte_in  (byte_s1),
		.cur_desc (cur_desc_q),
		.nxt      (nxt_st),
		.res      (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_desc_q <= 2'd2;
		end else if (cfg_wr_en) begin
			cur_desc_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[ch_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage payload; forward hit when this edge's write-back hits the entry being read
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1    <= rx.byte_in;
			ch_s1      <= rx.channel;
			fwd_hit_s1 <= wr_en && (ch_s1 == rx.channel);
			fwd_st_s1  <= nxt_st;
			vld_s1     <= vld_q[rx.channel];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wr_en && upd.emit) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && upd.emit) begin
			kind_q    <= upd.kind;
			och_q     <= ch_s1;
			data_q    <= upd.data;
			verdict_q <= upd.verdict;
			rid_q     <= upd.rid;
			desc_q    <= upd.desc;
			plen_q    <= upd.plen;
		end
	end

	assign res.valid            = out_valid_q;
	assign res.result_kind      = kind_q;
	assign res.out_channel      = och_q;
	assign res.data_byte        = data_q;
	assign res.verdict          = verdict_q;
	assign res.rep_id           = rid_q;
	assign res.frame_descriptor = desc_q;
	assign res.payload_length   = plen_q;
endmodule

// ===== src/sdc_checker.sv =====
// sdc_checker: port-level checks on the SLIP deframer, bound to the top level.
// Depends on sdc_pkg and slip_deframer_crc_packet_check.
module sdc_checker
	import sdc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       rx_valid,
	input logic       rx_ready,
	input logic       res_valid,
	input logic       res_ready,
	input logic       res_kind,
	input logic [7:0] res_data,
	input logic [2:0] res_verdict,
	input logic [6:0] res_plen
);
	// held result keeps its payload
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_data) && $stable(res_verdict))
		else $error("result changed while stalled");

	// a fresh result always follows an earlier rx transaction
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(rx_valid && rx_ready, 2))
		else $error("result without a preceding byte");

	// empty output register means the input is never stalled
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> rx_ready)
		else $error("input stalled with output register empty");

	// payload length only on accepted frames
	a_plen: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_plen != 7'd0 |->
			res_kind == KIND_VERDICT && (res_verdict == VERD_OK || res_verdict == VERD_NEW_DESC))
		else $error("payload length on a rejected frame");
endmodule

bind slip_deframer_crc_packet_check sdc_checker u_sdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rx_valid    (rx.valid),
	.rx_ready    (rx.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_kind    (res.result_kind),
	.res_data    (res.data_byte),
	.res_verdict (res.verdict),
	.res_plen    (res.payload_length)
);
